[hdl/dllm_pkg.sv]
// Shared types and constants of the doubly linked list manager.
// Holds the operation codes, controller states and the command/status structs.
// No dependencies.
package dllm_pkg;

  localparam int unsigned NodeW    = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 1;

  typedef enum logic [FuncW-1:0] {
    FN_CLEAR        = 3'd0,
    FN_ADD_FRONT    = 3'd1,
    FN_ADD_BACK     = 3'd2,
    FN_REMOVE_NODE  = 3'd3,
    FN_REMOVE_FRONT = 3'd4,
    FN_REMOVE_BACK  = 3'd5,
    FN_GET_FIRST    = 3'd6,
    FN_GET_NEXT     = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LINK2,
    ST_UNLINK,
    ST_WIPE,
    ST_FIN
  } state_e;

  // Controller to datapath: one strobe per step of an operation.
  typedef struct packed {
    logic req_load;
    logic exec;
    logic link2;
    logic unlink;
    logic wipe;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    func_e func;
    logic  node_null;
    logic  head_none;
    logic  tail_none;
    logic  out_stall;
  } sts_t;

endpackage

[hdl/dllm_ctrl.sv]
// Controller of the doubly linked list manager: sequences each request
// through execute, link, unlink and wipe steps. Depends on dllm_pkg.
module dllm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  dllm_pkg::sts_t sts_i,
  output dllm_pkg::cmd_t cmd_o
);

  dllm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dllm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      dllm_pkg::ST_IDLE: begin
        cmd_o.req_load = s_valid_i;
        if (s_valid_i) begin
          state_d = dllm_pkg::ST_EXEC;
        end
      end
      dllm_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (sts_i.func) inside
          dllm_pkg::FN_ADD_FRONT: begin
            state_d = (sts_i.node_null || sts_i.head_none) ? dllm_pkg::ST_FIN
                                                           : dllm_pkg::ST_LINK2;
          end
          dllm_pkg::FN_ADD_BACK: begin
            state_d = (sts_i.node_null || sts_i.tail_none) ? dllm_pkg::ST_FIN
                                                           : dllm_pkg::ST_LINK2;
          end
          dllm_pkg::FN_REMOVE_NODE, dllm_pkg::FN_GET_NEXT: begin
            state_d = sts_i.node_null ? dllm_pkg::ST_FIN : dllm_pkg::ST_UNLINK;
          end
          dllm_pkg::FN_REMOVE_FRONT: begin
            state_d = sts_i.head_none ? dllm_pkg::ST_FIN : dllm_pkg::ST_UNLINK;
          end
          dllm_pkg::FN_REMOVE_BACK: begin
            state_d = sts_i.tail_none ? dllm_pkg::ST_FIN : dllm_pkg::ST_UNLINK;
          end
          default: begin
            state_d = dllm_pkg::ST_FIN;
          end
        endcase
      end
      dllm_pkg::ST_LINK2: begin
        cmd_o.link2 = 1'b1;
        state_d     = dllm_pkg::ST_FIN;
      end
      dllm_pkg::ST_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = (sts_i.func == dllm_pkg::FN_GET_NEXT) ? dllm_pkg::ST_FIN
                                                        : dllm_pkg::ST_WIPE;
      end
      dllm_pkg::ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        state_d    = dllm_pkg::ST_FIN;
      end
      dllm_pkg::ST_FIN: begin
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = dllm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dllm_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_ready_o = (state_q == dllm_pkg::ST_IDLE);

endmodule

[hdl/dllm_datapath.sv]
// Datapath of the doubly linked list manager: link memories with valid bits,
// head, tail, count, request and result registers. Depends on dllm_pkg.
module dllm_datapath #(
  parameter int unsigned NODES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dllm_pkg::cmd_t              cmd_i,
  output dllm_pkg::sts_t              sts_o,
  input  logic [dllm_pkg::FuncW-1:0]  in_func_i,
  input  logic [dllm_pkg::NodeW-1:0]  in_node_i,
  input  logic                        in_null_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dllm_pkg::NodeW-1:0]  out_node_o,
  output logic                        out_none_o,
  output logic [dllm_pkg::CountW-1:0] out_count_o
);

  localparam int unsigned SLOTS = (NODES < 256) ? NODES : 256;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW    = $clog2(NODES + 1);
  localparam logic [LW-1:0] NONE = LW'(NODES);

  // Request registers
  dllm_pkg::func_e func_q;
  logic [LW-1:0]   node_q;
  logic            null_q;

  logic [LW-1:0] head_q, head_d, tail_q, tail_d;
  logic [dllm_pkg::CountW-1:0] total_q, total_d;
  logic [LW-1:0] tgt_q, tgt_d, res_q, res_d, tgt_sel;

  // Link memories
  logic [LW-1:0] next_mem [SLOTS];
  logic [LW-1:0] prev_mem [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [LW-1:0] rd_next_q, rd_prev_q;
  logic          rd_valid_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic          nx_we, pv_we, v_set;
  logic [AW-1:0] nx_wa, pv_wa, v_addr;
  logic [LW-1:0] nx_wd, pv_wd;
  logic [LW-1:0] lnk_p, lnk_n;

  logic                        out_valid_q;
  logic [dllm_pkg::NodeW-1:0]  out_node_q;
  logic                        out_none_q;
  logic [dllm_pkg::CountW-1:0] out_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      func_q <= dllm_pkg::func_e'(in_func_i);
      node_q <= LW'(in_node_i);
      null_q <= in_null_i | (32'(in_node_i) >= NODES);
    end
    tgt_q <= tgt_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NONE;
      tail_q  <= NONE;
      total_q <= '0;
      valid_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      total_q <= total_d;
      if (v_set) begin
        valid_q[v_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (rd_en) begin
      rd_next_q  <= next_mem[rd_addr];
      rd_prev_q  <= prev_mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // Never-written slots read as unlinked
  assign lnk_p = rd_valid_q ? rd_prev_q : NONE;
  assign lnk_n = rd_valid_q ? rd_next_q : NONE;

  always_comb begin
    case (func_q) inside
      dllm_pkg::FN_ADD_FRONT, dllm_pkg::FN_REMOVE_FRONT: tgt_sel = head_q;
      dllm_pkg::FN_ADD_BACK, dllm_pkg::FN_REMOVE_BACK:   tgt_sel = tail_q;
      default:                                           tgt_sel = node_q;
    endcase
  end

  assign rd_addr = AW'(tgt_sel);
  assign rd_en   = cmd_i.exec && (tgt_sel != NONE);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    total_d = total_q;
    tgt_d   = tgt_q;
    res_d   = res_q;
    nx_we   = 1'b0;
    nx_wa   = AW'(node_q);
    nx_wd   = NONE;
    pv_we   = 1'b0;
    pv_wa   = AW'(node_q);
    pv_wd   = NONE;
    v_set   = 1'b0;
    v_addr  = AW'(node_q);

    if (cmd_i.exec) begin
      tgt_d = tgt_sel;
      res_d = NONE;
      case (func_q)
        dllm_pkg::FN_CLEAR: begin
          head_d  = NONE;
          tail_d  = NONE;
          total_d = '0;
        end
        dllm_pkg::FN_ADD_FRONT: begin
          if (!null_q) begin
            nx_we = 1'b1;
            nx_wd = head_q;
            pv_we = 1'b1;
            v_set = 1'b1;
            if (head_q == NONE) begin
              tail_d = node_q;
            end
            head_d  = node_q;
            total_d = total_q + 9'd1;
          end
        end
        dllm_pkg::FN_ADD_BACK: begin
          if (!null_q) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            pv_wd = tail_q;
            v_set = 1'b1;
            if (tail_q == NONE) begin
              head_d = node_q;
            end
            tail_d  = node_q;
            total_d = total_q + 9'd1;
          end
        end
        dllm_pkg::FN_GET_FIRST: begin
          res_d = head_q;
        end
        default: begin
        end
      endcase
    end

    // Point the old end node at the new one
    if (cmd_i.link2) begin
      if (func_q == dllm_pkg::FN_ADD_FRONT) begin
        pv_we = 1'b1;
        pv_wa = AW'(tgt_q);
        pv_wd = node_q;
      end else begin
        nx_we = 1'b1;
        nx_wa = AW'(tgt_q);
        nx_wd = node_q;
      end
    end

    if (cmd_i.unlink) begin
      if (func_q == dllm_pkg::FN_GET_NEXT) begin
        res_d = lnk_n;
      end else if (head_q != NONE) begin
        if (lnk_p != NONE) begin
          nx_we = 1'b1;
          nx_wa = AW'(lnk_p);
          nx_wd = lnk_n;
        end else begin
          head_d = lnk_n;
        end
        if (lnk_n != NONE) begin
          pv_we = 1'b1;
          pv_wa = AW'(lnk_n);
          pv_wd = lnk_p;
        end else begin
          tail_d = lnk_p;
        end
        total_d = total_q - 9'd1;
      end
    end

    // Drop the removed node's own links
    if (cmd_i.wipe) begin
      nx_we  = 1'b1;
      nx_wa  = AW'(tgt_q);
      pv_we  = 1'b1;
      pv_wa  = AW'(tgt_q);
      v_set  = 1'b1;
      v_addr = AW'(tgt_q);
      res_d  = tgt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_none_q  <= (res_q == NONE);
      out_node_q  <= (res_q == NONE) ? '0 : dllm_pkg::NodeW'(res_q);
      out_count_q <= total_q;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.node_null = null_q;
  assign sts_o.head_none = (head_q == NONE);
  assign sts_o.tail_none = (tail_q == NONE);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_none_o  = out_none_q;
  assign out_count_o = out_count_q;

endmodule

[hdl/doubly_linked_list_manager.sv]
// Top level of the doubly linked list manager: stream ports, controller and
// datapath. Depends on dllm_pkg, dllm_ctrl and dllm_datapath.
//
// Channel   Dir  Handshake                        Word
// s_axis    in   s_axis_tvalid_i / s_axis_tready_o  request: node, func, null flag
// m_axis    out  m_axis_tvalid_o / m_axis_tready_i  result: node, count, none flag
//
// Steps per word: clear and get_first only execute; an add adds a link step, a get_next
// an unlink step, a removal unlink and wipe steps; the result register then loads once
// m_axis_tready_i frees it. The extra steps are skipped for a null node, or an empty
// list end for an add, remove_front or remove_back. The steps follow from the single
// write port on each link memory and its registered read: a removal reads the node's
// links, then rewrites both neighbours, then clears the node itself.
// Reset: link memories read as unlinked through one valid bit per slot, so no
// clearing pass is needed; the block is ready to take a word as soon as reset ends.
// Stalls: one result word is held in the output register while the next
// request word is taken; processing waits only when its result would overwrite it.
module doubly_linked_list_manager #(
  parameter int unsigned NODES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] node
  input  logic [dllm_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [2:0] func, [3] node_is_null
  input  logic [dllm_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] result_node, [16:8] list_count, [23:17] zero
  output logic [dllm_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] result_none
  output logic [dllm_pkg::OutUserW-1:0] m_axis_tuser_o
);

  dllm_pkg::cmd_t cmd;
  dllm_pkg::sts_t sts;

  logic [dllm_pkg::NodeW-1:0]  res_node;
  logic                        res_none;
  logic [dllm_pkg::CountW-1:0] res_count;

  // Sequence each request word through its steps
  dllm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Link tables, list ends, count and the result register
  dllm_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_func_i   (s_axis_tuser_i[2:0]),
    .in_node_i   (s_axis_tdata_i),
    .in_null_i   (s_axis_tuser_i[3]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_node_o  (res_node),
    .out_none_o  (res_none),
    .out_count_o (res_count)
  );

  // Pack the result word, low field first, zero fill to whole bytes
  assign m_axis_tdata_o = {7'd0, res_count, res_node};
  assign m_axis_tuser_o = res_none;

  // A loaded result is presented in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("result word not presented after load");

  // Never overwrite a result word that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("pending result word overwritten");

  // Busy for the cycle after a request word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while previous one in flight");

  // At most one step strobe at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.req_load, cmd.exec, cmd.link2, cmd.unlink, cmd.wipe, cmd.out_load}))
    else $error("controller issued overlapping steps");

endmodule
